// ----- src/dwf_pkg.sv -----
// ----------------------------------------------------------------------------
// dwf_pkg
// Shared types and constants for the display write framer.
// ----------------------------------------------------------------------------
package dwf_pkg;

    localparam int unsigned TPU_W     = 10;
    localparam int unsigned Q_DEPTH   = 2;
    localparam int unsigned Q_PTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int unsigned Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [TPU_W-1:0] TPU_RESET  = 10'd100;
    localparam logic [7:0]       ADDR_RESET = 8'h78;
    localparam logic [7:0]       CTRL_CMD   = 8'h00;
    localparam logic [7:0]       CTRL_DATA  = 8'h40;

    localparam logic [2:0] PADDR_TPU  = 3'd0;
    localparam logic [2:0] PADDR_ADDR = 3'd4;

    // hold lengths in microseconds, minus one
    localparam logic [2:0] US_START_A = 3'd4;
    localparam logic [2:0] US_START_B = 3'd5;
    localparam logic [2:0] US_BIT     = 3'd1;
    localparam logic [2:0] US_ACK     = 3'd2;
    localparam logic [2:0] US_STOP    = 3'd5;

    typedef enum logic [3:0] {
        SEG_IDLE,
        SEG_START_A,
        SEG_START_B,
        SEG_BIT_SET,
        SEG_BIT_HIGH,
        SEG_BIT_LOW,
        SEG_ACK_HIGH,
        SEG_ACK_LOW,
        SEG_STOP_A,
        SEG_STOP_B
    } t_seg;

    typedef struct packed {
        logic       req;
        logic [7:0] payload;
        logic       is_data;
    } t_item;

    typedef struct packed {
        logic dropped;
        logic busy_res;
        logic sda;
        logic scl;
    } t_result;

endpackage

// ----- src/dwf_front.sv -----
// ----------------------------------------------------------------------------
// dwf_front
// Input side: takes stream beats, tags requests and queues them for the engine.
// ----------------------------------------------------------------------------
module dwf_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_command,
    input  logic [7:0]          i_payload,
    input  logic                i_is_data,
    output logic                o_item_valid,
    input  logic                i_item_ready,
    output dwf_pkg::t_item      o_item
);

    dwf_pkg::t_item                  r_q [dwf_pkg::Q_DEPTH];
    logic [dwf_pkg::Q_PTR_W-1:0]     r_wr;
    logic [dwf_pkg::Q_PTR_W-1:0]     r_rd;
    logic [dwf_pkg::Q_CNT_W-1:0]     r_cnt;
    logic [dwf_pkg::Q_CNT_W-1:0]     n_cnt;
    logic                            push;
    logic                            pop;
    dwf_pkg::t_item                  in_item;

    localparam logic [dwf_pkg::Q_CNT_W-1:0] FULL = dwf_pkg::Q_CNT_W'(dwf_pkg::Q_DEPTH);
    localparam logic [dwf_pkg::Q_PTR_W-1:0] LAST = dwf_pkg::Q_PTR_W'(dwf_pkg::Q_DEPTH - 1);

    assign o_ready      = (r_cnt != FULL);
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_q[r_rd];
    assign push         = i_valid && o_ready;
    assign pop          = o_item_valid && i_item_ready;

    always_comb begin
        in_item.req     = i_command;
        in_item.payload = i_payload;
        in_item.is_data = i_is_data;
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= in_item;
        end
    end

endmodule

// ----- src/dwf_back.sv -----
// ----------------------------------------------------------------------------
// dwf_back
// Bus engine: steps the segment timer once per queued beat and registers the
// line levels for the output stream.
// ----------------------------------------------------------------------------
module dwf_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [dwf_pkg::TPU_W-1:0]   i_ticks_per_us,
    input  logic [7:0]                  i_device_address,
    input  logic                        i_item_valid,
    output logic                        o_item_ready,
    input  dwf_pkg::t_item              i_item,
    output logic                        o_valid,
    input  logic                        i_ready,
    output dwf_pkg::t_result            o_result
);

    dwf_pkg::t_seg                r_seg,   n_seg;
    logic [1:0]                   r_byte,  n_byte;
    logic [2:0]                   r_bit,   n_bit;
    logic [7:0]                   r_shift, n_shift;
    logic [7:0]                   r_held,  n_held;
    logic                         r_hdata, n_hdata;
    logic [2:0]                   r_us,    n_us;
    logic [dwf_pkg::TPU_W-1:0]    r_tick,  n_tick;
    logic                         r_out_valid;
    dwf_pkg::t_result             r_out,   n_out;
    logic [dwf_pkg::TPU_W-1:0]    reload;
    logic                         live;
    logic                         take;
    logic                         bitv;

    assign o_item_ready = !r_out_valid || i_ready;
    assign take         = i_item_valid && o_item_ready;
    assign o_valid      = r_out_valid;
    assign o_result     = r_out;
    assign reload       = (i_ticks_per_us == '0) ? '0 : i_ticks_per_us - 1'b1;
    assign live         = (r_seg >= dwf_pkg::SEG_START_A) && (r_seg <= dwf_pkg::SEG_STOP_B);

    always_comb begin
        n_seg   = r_seg;
        n_byte  = r_byte;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_held  = r_held;
        n_hdata = r_hdata;
        n_us    = r_us;
        n_tick  = r_tick;
        n_out.scl      = 1'b1;
        n_out.sda      = 1'b1;
        n_out.busy_res = 1'b0;
        n_out.dropped  = 1'b0;
        bitv = 1'b1;

        if (!live) begin
            n_seg = dwf_pkg::SEG_IDLE;
            if (i_item.req) begin
                n_held  = i_item.payload;
                n_hdata = i_item.is_data;
                n_shift = i_device_address;
                n_byte  = '0;
                n_bit   = '0;
                n_seg   = dwf_pkg::SEG_START_A;
                n_us    = dwf_pkg::US_START_A;
                n_tick  = reload;
            end
        end else if (i_item.req) begin
            n_out.dropped = 1'b1;
        end

        if (n_seg != dwf_pkg::SEG_IDLE) begin
            n_out.busy_res = 1'b1;
            bitv = n_shift[7];
            case (n_seg)
                dwf_pkg::SEG_START_A:  begin n_out.scl = 1'b1; n_out.sda = 1'b1; end
                dwf_pkg::SEG_START_B:  begin n_out.scl = 1'b1; n_out.sda = 1'b0; end
                dwf_pkg::SEG_BIT_SET:  begin n_out.scl = 1'b0; n_out.sda = bitv; end
                dwf_pkg::SEG_BIT_HIGH: begin n_out.scl = 1'b1; n_out.sda = bitv; end
                dwf_pkg::SEG_BIT_LOW:  begin n_out.scl = 1'b0; n_out.sda = bitv; end
                dwf_pkg::SEG_ACK_HIGH: begin n_out.scl = 1'b1; n_out.sda = 1'b1; end
                dwf_pkg::SEG_ACK_LOW:  begin n_out.scl = 1'b0; n_out.sda = 1'b1; end
                dwf_pkg::SEG_STOP_A:   begin n_out.scl = 1'b1; n_out.sda = 1'b0; end
                default:               begin n_out.scl = 1'b1; n_out.sda = 1'b1; end
            endcase

            if (n_tick != '0) begin
                n_tick = n_tick - 1'b1;
            end else if (n_us != '0) begin
                n_us   = n_us - 1'b1;
                n_tick = reload;
            end else begin
                n_tick = reload;
                case (n_seg)
                    dwf_pkg::SEG_START_A: begin
                        n_seg = dwf_pkg::SEG_START_B;
                        n_us  = dwf_pkg::US_START_B;
                    end
                    dwf_pkg::SEG_START_B: begin
                        n_seg = dwf_pkg::SEG_BIT_SET;
                        n_us  = dwf_pkg::US_BIT;
                    end
                    dwf_pkg::SEG_BIT_SET: begin
                        n_seg = dwf_pkg::SEG_BIT_HIGH;
                        n_us  = dwf_pkg::US_BIT;
                    end
                    dwf_pkg::SEG_BIT_HIGH: begin
                        n_seg = dwf_pkg::SEG_BIT_LOW;
                        n_us  = dwf_pkg::US_BIT;
                    end
                    dwf_pkg::SEG_BIT_LOW: begin
                        n_shift = {n_shift[6:0], 1'b0};
                        if (n_bit == 3'd7) begin
                            n_bit = '0;
                            n_seg = dwf_pkg::SEG_ACK_HIGH;
                            n_us  = dwf_pkg::US_ACK;
                        end else begin
                            n_bit = n_bit + 1'b1;
                            n_seg = dwf_pkg::SEG_BIT_SET;
                            n_us  = dwf_pkg::US_BIT;
                        end
                    end
                    dwf_pkg::SEG_ACK_HIGH: begin
                        n_seg = dwf_pkg::SEG_ACK_LOW;
                        n_us  = dwf_pkg::US_ACK;
                    end
                    dwf_pkg::SEG_ACK_LOW: begin
                        if (n_byte >= 2'd2) begin
                            n_seg = dwf_pkg::SEG_STOP_A;
                            n_us  = dwf_pkg::US_STOP;
                        end else begin
                            n_byte = n_byte + 1'b1;
                            if (n_byte == 2'd1) begin
                                n_shift = n_hdata ? dwf_pkg::CTRL_DATA : dwf_pkg::CTRL_CMD;
                            end else begin
                                n_shift = n_held;
                            end
                            n_seg = dwf_pkg::SEG_BIT_SET;
                            n_us  = dwf_pkg::US_BIT;
                        end
                    end
                    dwf_pkg::SEG_STOP_A: begin
                        n_seg = dwf_pkg::SEG_STOP_B;
                        n_us  = dwf_pkg::US_STOP;
                    end
                    default: begin
                        n_seg  = dwf_pkg::SEG_IDLE;
                        n_us   = '0;
                        n_tick = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg       <= dwf_pkg::SEG_IDLE;
            r_byte      <= '0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_held      <= '0;
            r_hdata     <= 1'b0;
            r_us        <= '0;
            r_tick      <= '0;
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_seg       <= n_seg;
            r_byte      <= n_byte;
            r_bit       <= n_bit;
            r_shift     <= n_shift;
            r_held      <= n_held;
            r_hdata     <= n_hdata;
            r_us        <= n_us;
            r_tick      <= n_tick;
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

    a_drop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.dropped |-> r_out.busy_res)
        else $error("dropped beat reported while not busy");

    a_idle_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seg == dwf_pkg::SEG_IDLE |-> (r_us == '0) && (r_tick == '0))
        else $error("timer not cleared in idle");

    a_us_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_us <= dwf_pkg::US_START_B)
        else $error("microsecond count out of range");

    a_start_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seg == dwf_pkg::SEG_START_A |-> (r_byte == '0) && (r_bit == '0))
        else $error("slot counters not cleared at start");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_ready |=> $stable(r_seg) && $stable(r_tick))
        else $error("engine advanced while output stalled");

endmodule

// ----- src/i2c_display_write_framer.sv -----
// ----------------------------------------------------------------------------
// i2c_display_write_framer
// Write-only bit-level I2C master framing single-byte display writes.
// ----------------------------------------------------------------------------
// Every input beat is one bus timer tick and yields exactly one output beat
// with the SCL/SDA levels for that tick plus busy and dropped flags.
// Input: s_axis_tdata carries the payload byte, s_axis_tuser carries the
// request flag and the data/command flag. A request seen while idle starts
// a frame: start, device address, control byte, payload (each followed by an
// unsampled acknowledge clock), stop. Requests seen while busy are dropped.
// Beats pass a two-entry queue into the engine; the engine steps once per beat
// and registers its result, so a beat passes the queue and the output register,
// and a beat is taken every cycle while the receiver keeps m_axis_tready high.
// When the receiver stalls the engine holds and the queue fills; s_axis_tready
// falls once two beats wait. Reset empties the queue and output register,
// returns the engine to idle, and loads ticks_per_us = 100 and
// device_address = 0x78. APB: ticks_per_us at 0x0, device_address at 0x4;
// write them only while the block is idle.
// ----------------------------------------------------------------------------
module i2c_display_write_framer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] payload
    input  logic [1:0]  s_axis_tuser,   // [0] command, [1] is_data
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] scl, [1] sda, [2] busy_res, [3] dropped
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [dwf_pkg::TPU_W-1:0] r_tpu;
    logic [7:0]                r_addr;
    logic                      cfg_wr;
    logic                      item_valid;
    logic                      item_ready;
    dwf_pkg::t_item            item;
    dwf_pkg::t_result          result;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpu  <= dwf_pkg::TPU_RESET;
            r_addr <= dwf_pkg::ADDR_RESET;
        end else if (cfg_wr) begin
            if (paddr == dwf_pkg::PADDR_TPU) begin
                r_tpu <= pwdata[dwf_pkg::TPU_W-1:0];
            end
            if (paddr == dwf_pkg::PADDR_ADDR) begin
                r_addr <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        case (paddr)
            dwf_pkg::PADDR_TPU:  prdata = {{(32 - dwf_pkg::TPU_W){1'b0}}, r_tpu};
            dwf_pkg::PADDR_ADDR: prdata = {24'd0, r_addr};
            default:             prdata = '0;
        endcase
    end

    dwf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_command    (s_axis_tuser[0]),
        .i_payload    (s_axis_tdata),
        .i_is_data    (s_axis_tuser[1]),
        .o_item_valid (item_valid),
        .i_item_ready (item_ready),
        .o_item       (item)
    );

    dwf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ticks_per_us   (r_tpu),
        .i_device_address (r_addr),
        .i_item_valid     (item_valid),
        .o_item_ready     (item_ready),
        .i_item           (item),
        .o_valid          (m_axis_tvalid),
        .i_ready          (m_axis_tready),
        .o_result         (result)
    );

    assign m_axis_tdata = {4'd0, result.dropped, result.busy_res, result.sda, result.scl};

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the I2C display write framer. Every input beat is
// one bus timer tick and yields one output beat with the SCL/SDA levels. A
// cycle-level model of the framer predicts each output beat as its input beat
// is taken. A short table of directed ticks runs first at one tick per
// microsecond. Random phases follow at several bus timings and device
// addresses, with stalls on both sides. A final burst runs at the slowest timing.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          STALL_LIMIT   = 2000;
    localparam int          RX_HOLD_TICKS = 40;
    localparam int          PHASE_BEATS   = 60;
    localparam int          ERR_PRINT_MAX = 50;

    localparam logic [2:0]  HOLD_START_A = 3'd4;
    localparam logic [2:0]  HOLD_START_B = 3'd5;
    localparam logic [2:0]  HOLD_BIT     = 3'd1;
    localparam logic [2:0]  HOLD_ACK     = 3'd2;
    localparam logic [2:0]  HOLD_STOP    = 3'd5;

    typedef struct packed {
        logic       drain;
        logic       req;
        logic [7:0] payload;
        logic       is_data;
        logic       fixed;
        logic       scl;
        logic       sda;
        logic       busy;
        logic       dropped;
    } t_step_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] payload
    logic [1:0]  s_axis_tuser  = 2'b00;   // [0] command, [1] is_data
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;            // [0] scl, [1] sda, [2] busy_res, [3] dropped
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = 3'd0;
    logic [31:0] pwdata        = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    // framer model state
    dwf_pkg::t_seg seg        = dwf_pkg::SEG_IDLE;
    logic [1:0]  byte_idx     = 2'd0;
    logic [2:0]  bit_idx      = 3'd0;
    logic [7:0]  shreg        = 8'h00;
    logic [7:0]  pend_payload = 8'h00;
    logic        pend_is_data = 1'b0;
    logic [2:0]  us_left      = 3'd0;
    logic [9:0]  tick_left    = 10'd0;
    logic [9:0]  cfg_tpu      = dwf_pkg::TPU_RESET;
    logic [7:0]  cfg_addr     = dwf_pkg::ADDR_RESET;

    dwf_pkg::t_result expected_levels[$];
    logic        gaps_on      = 1'b0;
    logic        rx_hold_req  = 1'b0;
    int          err_count    = 0;
    int          in_beats     = 0;
    int          out_beats    = 0;
    int          frames_started = 0;
    int          drops_seen   = 0;
    int          stall_cycles = 0;

    // drain, req, payload, is_data, fixed, scl, sda, busy, dropped
    t_step_row step_rows [0:12] = '{
        '{1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
        '{1'b0, 1'b0, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
        '{1'b0, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
        '{1'b0, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1},
        '{1'b0, 1'b0, 8'h3C, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b1, 8'h5A, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b1, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
        '{1'b0, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1},
        '{1'b0, 1'b0, 8'hC3, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b1, 8'h81, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b1, 8'h7E, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}
    };

    i2c_display_write_framer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #6 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        if (err_count <= ERR_PRINT_MAX) begin
            $display("MISMATCH %s: got %0h, expected %0h (output beat %0d)",
                     what, got, want, out_beats);
        end
    endtask

    function automatic logic [9:0] tick_reload();
        return (cfg_tpu == 10'd0) ? 10'd0 : cfg_tpu - 10'd1;
    endfunction

    task automatic enter_hold(input dwf_pkg::t_seg next_seg, input logic [2:0] us_m1);
        seg       = next_seg;
        us_left   = us_m1;
        tick_left = tick_reload();
    endtask

    task automatic advance_segment();
        case (seg)
            dwf_pkg::SEG_START_A:  enter_hold(dwf_pkg::SEG_START_B, HOLD_START_B);
            dwf_pkg::SEG_START_B:  enter_hold(dwf_pkg::SEG_BIT_SET, HOLD_BIT);
            dwf_pkg::SEG_BIT_SET:  enter_hold(dwf_pkg::SEG_BIT_HIGH, HOLD_BIT);
            dwf_pkg::SEG_BIT_HIGH: enter_hold(dwf_pkg::SEG_BIT_LOW, HOLD_BIT);
            dwf_pkg::SEG_BIT_LOW: begin
                shreg = {shreg[6:0], 1'b0};
                if (bit_idx == 3'd7) begin
                    bit_idx = 3'd0;
                    enter_hold(dwf_pkg::SEG_ACK_HIGH, HOLD_ACK);
                end else begin
                    bit_idx = bit_idx + 3'd1;
                    enter_hold(dwf_pkg::SEG_BIT_SET, HOLD_BIT);
                end
            end
            dwf_pkg::SEG_ACK_HIGH: enter_hold(dwf_pkg::SEG_ACK_LOW, HOLD_ACK);
            dwf_pkg::SEG_ACK_LOW: begin
                if (byte_idx >= 2'd2) begin
                    enter_hold(dwf_pkg::SEG_STOP_A, HOLD_STOP);
                end else begin
                    byte_idx = byte_idx + 2'd1;
                    if (byte_idx == 2'd1) begin
                        shreg = pend_is_data ? dwf_pkg::CTRL_DATA : dwf_pkg::CTRL_CMD;
                    end else begin
                        shreg = pend_payload;
                    end
                    enter_hold(dwf_pkg::SEG_BIT_SET, HOLD_BIT);
                end
            end
            dwf_pkg::SEG_STOP_A:   enter_hold(dwf_pkg::SEG_STOP_B, HOLD_STOP);
            default: begin
                seg       = dwf_pkg::SEG_IDLE;
                us_left   = 3'd0;
                tick_left = 10'd0;
            end
        endcase
    endtask

    task automatic step_bus(input dwf_pkg::t_item it, output dwf_pkg::t_result lv);
        logic b;
        lv     = '0;
        lv.scl = 1'b1;
        lv.sda = 1'b1;
        if (seg == dwf_pkg::SEG_IDLE) begin
            if (it.req) begin
                pend_payload = it.payload;
                pend_is_data = it.is_data;
                shreg        = cfg_addr;
                byte_idx     = 2'd0;
                bit_idx      = 3'd0;
                enter_hold(dwf_pkg::SEG_START_A, HOLD_START_A);
                frames_started++;
            end
        end else if (it.req) begin
            lv.dropped = 1'b1;
            drops_seen++;
        end
        if (seg != dwf_pkg::SEG_IDLE) begin
            lv.busy_res = 1'b1;
            b = shreg[7];
            case (seg)
                dwf_pkg::SEG_START_B, dwf_pkg::SEG_STOP_A: lv.sda = 1'b0;
                dwf_pkg::SEG_BIT_SET, dwf_pkg::SEG_BIT_LOW: begin
                    lv.scl = 1'b0;
                    lv.sda = b;
                end
                dwf_pkg::SEG_BIT_HIGH: lv.sda = b;
                dwf_pkg::SEG_ACK_LOW:  lv.scl = 1'b0;
                default: ;
            endcase
            if (tick_left != 10'd0) begin
                tick_left = tick_left - 10'd1;
            end else if (us_left != 3'd0) begin
                us_left   = us_left - 3'd1;
                tick_left = tick_reload();
            end else begin
                advance_segment();
            end
        end
    endtask

    task automatic check_register(input logic [2:0] addr);
        logic [31:0] rd;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == dwf_pkg::PADDR_TPU) begin
            if (rd[9:0] != cfg_tpu) begin
                report_mismatch("ticks_per_us readback", rd, 32'(cfg_tpu));
            end
        end else if (rd[7:0] != cfg_addr) begin
            report_mismatch("device_address readback", rd, 32'(cfg_addr));
        end
    endtask

    task automatic set_register(input logic [2:0] addr, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == dwf_pkg::PADDR_TPU) begin
            cfg_tpu = value[9:0];
        end else begin
            cfg_addr = value[7:0];
        end
        check_register(addr);
    endtask

    task automatic send_beat(input dwf_pkg::t_item it, input logic fixed,
                             input dwf_pkg::t_result fixed_lv);
        dwf_pkg::t_result want;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it.payload;
        s_axis_tuser  <= {it.is_data, it.req};
        do @(posedge i_clk); while (!s_axis_tready);
        in_beats++;
        step_bus(it, want);
        expected_levels.push_back(fixed ? fixed_lv : want);
    endtask

    task automatic finish_frame();
        dwf_pkg::t_item it;
        while (seg != dwf_pkg::SEG_IDLE) begin
            it.req     = 1'b0;
            it.payload = 8'($urandom_range(0, 255));
            it.is_data = 1'($urandom_range(0, 1));
            send_beat(it, 1'b0, '0);
        end
    endtask

    // hold the input until every beat is out and the engine is quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_levels.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : level_check
        dwf_pkg::t_result got;
        dwf_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            out_beats++;
            got = dwf_pkg::t_result'(m_axis_tdata[3:0]);
            if (expected_levels.size() == 0) begin
                report_mismatch("beat with nothing expected", 32'(m_axis_tdata), 32'h0);
            end else begin
                want = expected_levels.pop_front();
                if (got.scl != want.scl) begin
                    report_mismatch("scl", 32'(got.scl), 32'(want.scl));
                end
                if (got.sda != want.sda) begin
                    report_mismatch("sda", 32'(got.sda), 32'(want.sda));
                end
                if (got.busy_res != want.busy_res) begin
                    report_mismatch("busy_res", 32'(got.busy_res), 32'(want.busy_res));
                end
                if (got.dropped != want.dropped) begin
                    report_mismatch("dropped", 32'(got.dropped), 32'(want.dropped));
                end
                if (m_axis_tdata[7:4] != 4'h0) begin
                    report_mismatch("tdata padding", 32'(m_axis_tdata[7:4]), 32'h0);
                end
            end
        end
    end

    initial begin : rx_side
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_TICKS) @(posedge i_clk);
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (stall_cycles >= STALL_LIMIT);
        $display("no beat moved for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        dwf_pkg::t_item   it;
        dwf_pkg::t_result fixed_lv;
        logic [9:0] phase_tpu [0:3];
        logic [7:0] phase_addr [0:3];
        phase_tpu  = '{10'd1, 10'd0, 10'd2, 10'd1};
        phase_addr = '{8'h00, 8'hFF, 8'h3C, 8'($urandom)};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        check_register(dwf_pkg::PADDR_TPU);
        check_register(dwf_pkg::PADDR_ADDR);
        set_register(dwf_pkg::PADDR_TPU, 32'd1);

        gaps_on = 1'b1;
        foreach (step_rows[r]) begin
            if (step_rows[r].drain) begin
                finish_frame();
            end
            it.req            = step_rows[r].req;
            it.payload        = step_rows[r].payload;
            it.is_data        = step_rows[r].is_data;
            fixed_lv.scl      = step_rows[r].scl;
            fixed_lv.sda      = step_rows[r].sda;
            fixed_lv.busy_res = step_rows[r].busy;
            fixed_lv.dropped  = step_rows[r].dropped;
            send_beat(it, step_rows[r].fixed, fixed_lv);
        end
        settle();

        for (int p = 0; p < 4; p++) begin
            set_register(dwf_pkg::PADDR_TPU, {22'($urandom), phase_tpu[p]});
            set_register(dwf_pkg::PADDR_ADDR, {24'($urandom), phase_addr[p]});
            for (int k = 0; k < PHASE_BEATS; k++) begin
                gaps_on = ((k % 64) < 40);
                if (p == 1 && k == 30) begin
                    rx_hold_req = 1'b1;
                end
                if (p == 2 && k == 40) begin
                    s_axis_tvalid <= 1'b0;
                    do @(posedge i_clk); while (expected_levels.size() != 0);
                end
                it.payload = 8'($urandom_range(0, 255));
                it.is_data = 1'($urandom_range(0, 1));
                if (seg == dwf_pkg::SEG_IDLE) begin
                    it.req = ($urandom_range(0, 3) == 0);
                end else begin
                    it.req = ($urandom_range(0, 15) == 0);
                end
                send_beat(it, 1'b0, '0);
            end
            settle();
        end

        // slowest timing, no stalls on either side
        gaps_on = 1'b0;
        set_register(dwf_pkg::PADDR_TPU, {22'($urandom), 10'd1023});
        set_register(dwf_pkg::PADDR_ADDR, {24'($urandom), 8'($urandom)});
        for (int k = 0; k < 4; k++) begin
            it.req     = (k == 2);
            it.payload = 8'($urandom_range(0, 255));
            it.is_data = 1'($urandom_range(0, 1));
            send_beat(it, 1'b0, '0);
        end
        settle();
        repeat (8) @(posedge i_clk);

        $display("covered %0d ticks in, %0d level beats out, %0d frames, %0d dropped requests",
                 in_beats, out_beats, frames_started, drops_seen);
        $display("bus timing 1, 0, 2 and 1023 ticks/us; addresses 0x78, 0x00, 0xFF, more");
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
